/* hdl/i2cm_pkg.sv */
// Shared types, codes and constants for the I2C master bit engine.
// Used by the command queue, the line engine and the top level; no dependencies.
package i2cm_pkg;

    // Field widths of one input beat and one result beat.
    localparam int OP_W       = 3;
    localparam int BYTE_W     = 8;
    localparam int PHASE_W    = 16;
    localparam int TIMEOUT_W  = 8;
    localparam int BITCNT_W   = 4;
    localparam int STEP_W     = 3;
    localparam int S_TDATA_W  = 16;
    localparam int M_TDATA_W  = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    // Default depth of the queue between the front and the back.
    localparam int QUEUE_DEPTH_DEF = 2;

    // Reset values and fixed counts.
    localparam logic [PHASE_W-1:0]   PHASE_TICKS_RST = 16'd5;
    localparam logic [TIMEOUT_W-1:0] ACK_TIMEOUT_RST = 8'd250;
    localparam logic [BITCNT_W-1:0]  BITS_PER_BYTE   = 4'd8;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_PHASE_TICKS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ACK_TIMEOUT = 2'd1;

    // Input op codes as they arrive on the bus.
    localparam logic [OP_W-1:0] OPC_TICK    = 3'd0;
    localparam logic [OP_W-1:0] OPC_START   = 3'd1;
    localparam logic [OP_W-1:0] OPC_STOP    = 3'd2;
    localparam logic [OP_W-1:0] OPC_SEND    = 3'd3;
    localparam logic [OP_W-1:0] OPC_WAITACK = 3'd4;
    localparam logic [OP_W-1:0] OPC_READ    = 3'd5;

    // Classified kind of an item, decided by the front.
    typedef enum logic [2:0] {
        KIND_TICK,
        KIND_START,
        KIND_STOP,
        KIND_SEND,
        KIND_WAITACK,
        KIND_READ,
        KIND_IGNORE
    } kind_t;

    // Command in progress in the line engine.
    typedef enum logic [2:0] {
        CMD_IDLE,
        CMD_START,
        CMD_STOP,
        CMD_SEND,
        CMD_WAITACK,
        CMD_READ
    } cmd_t;

    // One classified item as it sits in the queue.
    typedef struct packed {
        kind_t             kind;
        logic [BYTE_W-1:0] tx_byte;
        logic              ack_after_read;
        logic              sda_in;
    } item_t;

    // One result beat.
    typedef struct packed {
        logic              scl_out;
        logic              sda_out;
        logic              busy_res;
        logic [BYTE_W-1:0] rx_byte;
        logic              rx_valid;
        logic              ack_fail;
        logic              done_res;
    } result_t;

    // Map a raw op code onto its kind; the unused codes are ignored.
    function automatic kind_t classify(input logic [OP_W-1:0] op);
        kind_t k;
        case (op)
            OPC_TICK:    k = KIND_TICK;
            OPC_START:   k = KIND_START;
            OPC_STOP:    k = KIND_STOP;
            OPC_SEND:    k = KIND_SEND;
            OPC_WAITACK: k = KIND_WAITACK;
            OPC_READ:    k = KIND_READ;
            default:     k = KIND_IGNORE;
        endcase
        return k;
    endfunction

endpackage

/* hdl/i2cm_cmd_queue.sv */
// Front of the I2C master bit engine: accepts input beats, classifies the op
// and holds the items in a short queue for the line engine. Uses i2cm_pkg.
module i2cm_cmd_queue
    import i2cm_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [OP_W-1:0]     in_op,
    input  logic [BYTE_W-1:0]   in_tx_byte,
    input  logic                in_ack_after_read,
    input  logic                in_sda_in,
    output logic                q_valid,
    input  logic                q_ready,
    output item_t               q_item
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    item_t            entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             push, pop;
    item_t            new_item;

    // Classify the incoming beat.
    always_comb begin
        new_item.kind           = classify(in_op);
        new_item.tx_byte        = in_tx_byte;
        new_item.ack_after_read = in_ack_after_read;
        new_item.sda_in         = in_sda_in;
    end

    assign in_ready = (count_reg != CNT_FULL);
    assign q_valid  = (count_reg != '0);
    assign q_item   = entry_reg[rd_ptr_reg];
    assign push     = in_valid && in_ready;
    assign pop      = q_valid && q_ready;

    // Pointer and fill count updates.
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Queue storage needs no reset.
    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= new_item;
        end
    end

endmodule

/* hdl/i2cm_line_engine.sv */
// Back of the I2C master bit engine: SCL/SDA phase sequencer, one queued
// item per cycle unless stalled, into a result register. Uses i2cm_pkg.
module i2cm_line_engine
    import i2cm_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_idx,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    input  logic                  q_valid,
    output logic                  q_ready,
    input  item_t                 q_item,
    output logic                  res_valid,
    input  logic                  res_ready,
    output result_t               res
);

    logic [PHASE_W-1:0]   phase_ticks_reg;
    logic [TIMEOUT_W-1:0] ack_timeout_reg;

    cmd_t                 cmd_reg, cmd_next;
    logic [STEP_W-1:0]    step_reg, step_next;
    logic [BITCNT_W-1:0]  bitc_reg, bitc_next;
    logic [BYTE_W-1:0]    shift_reg, shift_next;
    logic [PHASE_W-1:0]   delay_reg, delay_next;
    logic [TIMEOUT_W-1:0] tmo_reg, tmo_next;
    logic                 ackc_reg, ackc_next;
    logic                 scl_reg, scl_next;
    logic                 sda_reg, sda_next;
    logic [BYTE_W-1:0]    rx_last_reg, rx_last_next;
    logic                 res_valid_reg, res_valid_next;
    result_t              res_reg, res_next;

    logic [PHASE_W-1:0]   phase_len;
    logic [PHASE_W-1:0]   delay_inc;
    logic [TIMEOUT_W-1:0] tmo_inc;
    logic [BITCNT_W-1:0]  bitc_inc;
    logic                 el_p, el_one;
    logic                 done, rxv, fail;
    logic                 step_en;

    // A new item is taken whenever the result stage is free or draining.
    assign q_ready = !res_valid_reg || res_ready;
    assign step_en = q_valid && q_ready;

    assign phase_len = (phase_ticks_reg == '0) ? PHASE_W'(1) : phase_ticks_reg;
    assign delay_inc = delay_reg + 1'b1;
    assign tmo_inc   = tmo_reg + 1'b1;
    assign bitc_inc  = bitc_reg + 1'b1;
    assign el_p      = (delay_inc >= phase_len);
    assign el_one    = (delay_inc != '0);

    // Configuration registers: write only while engine idle (unenforced).
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_ticks_reg <= PHASE_TICKS_RST;
            ack_timeout_reg <= ACK_TIMEOUT_RST;
        end else if (cfg_we) begin
            if (cfg_idx == CFG_PHASE_TICKS) begin
                phase_ticks_reg <= cfg_wdata;
            end else if (cfg_idx == CFG_ACK_TIMEOUT) begin
                ack_timeout_reg <= cfg_wdata[TIMEOUT_W-1:0];
            end
        end
    end

    // Phase sequencer: next state and result for the item at the queue head.
    always_comb begin
        cmd_next     = cmd_reg;
        step_next    = step_reg;
        bitc_next    = bitc_reg;
        shift_next   = shift_reg;
        delay_next   = delay_reg;
        tmo_next     = tmo_reg;
        ackc_next    = ackc_reg;
        scl_next     = scl_reg;
        sda_next     = sda_reg;
        rx_last_next = rx_last_reg;
        done         = 1'b0;
        rxv          = 1'b0;
        fail         = 1'b0;

        if (q_item.kind != KIND_TICK) begin
            // A command starts only when idle; otherwise it is dropped.
            if (cmd_reg == CMD_IDLE && q_item.kind != KIND_IGNORE) begin
                step_next  = '0;
                delay_next = '0;
                bitc_next  = '0;
                case (q_item.kind)
                    KIND_START: begin
                        cmd_next = CMD_START;
                        scl_next = 1'b1;
                        sda_next = 1'b1;
                    end
                    KIND_STOP: begin
                        cmd_next = CMD_STOP;
                        scl_next = 1'b0;
                        sda_next = 1'b0;
                    end
                    KIND_SEND: begin
                        cmd_next   = CMD_SEND;
                        scl_next   = 1'b0;
                        sda_next   = q_item.tx_byte[BYTE_W-1];
                        shift_next = {q_item.tx_byte[BYTE_W-2:0], 1'b0};
                    end
                    KIND_WAITACK: begin
                        cmd_next = CMD_WAITACK;
                        sda_next = 1'b1;
                        tmo_next = '0;
                    end
                    default: begin
                        cmd_next   = CMD_READ;
                        sda_next   = 1'b1;
                        scl_next   = 1'b0;
                        shift_next = '0;
                        ackc_next  = q_item.ack_after_read;
                    end
                endcase
            end
        end else begin
            case (cmd_reg)
                CMD_START: begin
                    delay_next = el_p ? '0 : delay_inc;
                    if (el_p) begin
                        if (step_reg == '0) begin
                            sda_next  = 1'b0;
                            step_next = STEP_W'(1);
                        end else begin
                            scl_next = 1'b0;
                            done     = 1'b1;
                        end
                    end
                end
                CMD_STOP: begin
                    delay_next = el_p ? '0 : delay_inc;
                    if (el_p) begin
                        if (step_reg == '0) begin
                            scl_next  = 1'b1;
                            sda_next  = 1'b1;
                            step_next = STEP_W'(1);
                        end else begin
                            done = 1'b1;
                        end
                    end
                end
                CMD_SEND: begin
                    delay_next = el_p ? '0 : delay_inc;
                    if (el_p) begin
                        if (step_reg == '0) begin
                            scl_next  = 1'b1;
                            step_next = STEP_W'(1);
                        end else if (step_reg == STEP_W'(1)) begin
                            scl_next  = 1'b0;
                            step_next = STEP_W'(2);
                        end else begin
                            bitc_next = bitc_inc;
                            if (bitc_inc >= BITS_PER_BYTE) begin
                                done = 1'b1;
                            end else begin
                                sda_next   = shift_reg[BYTE_W-1];
                                shift_next = {shift_reg[BYTE_W-2:0], 1'b0};
                                step_next  = '0;
                            end
                        end
                    end
                end
                CMD_WAITACK: begin
                    if (step_reg == '0) begin
                        delay_next = el_one ? '0 : delay_inc;
                        if (el_one) begin
                            scl_next  = 1'b1;
                            step_next = STEP_W'(1);
                        end
                    end else if (step_reg == STEP_W'(1)) begin
                        delay_next = el_one ? '0 : delay_inc;
                        if (el_one) begin
                            step_next = STEP_W'(2);
                        end
                    end else if (step_reg == STEP_W'(2)) begin
                        // Poll SDA; a low level is the acknowledge.
                        if (q_item.sda_in) begin
                            tmo_next = tmo_inc;
                            if (tmo_inc == '0 || tmo_inc >= ack_timeout_reg) begin
                                scl_next   = 1'b0;
                                sda_next   = 1'b0;
                                step_next  = STEP_W'(3);
                                delay_next = '0;
                            end
                        end else begin
                            scl_next = 1'b0;
                            done     = 1'b1;
                        end
                    end else if (step_reg == STEP_W'(3)) begin
                        delay_next = el_p ? '0 : delay_inc;
                        if (el_p) begin
                            scl_next  = 1'b1;
                            sda_next  = 1'b1;
                            step_next = STEP_W'(4);
                        end
                    end else begin
                        delay_next = el_p ? '0 : delay_inc;
                        if (el_p) begin
                            done = 1'b1;
                            fail = 1'b1;
                        end
                    end
                end
                CMD_READ: begin
                    delay_next = el_p ? '0 : delay_inc;
                    if (el_p) begin
                        if (step_reg == '0) begin
                            scl_next  = 1'b1;
                            step_next = STEP_W'(1);
                        end else if (step_reg == STEP_W'(1)) begin
                            // Sample at the end of the SCL high phase.
                            shift_next = {shift_reg[BYTE_W-2:0], q_item.sda_in};
                            bitc_next  = bitc_inc;
                            scl_next   = 1'b0;
                            if (bitc_inc >= BITS_PER_BYTE) begin
                                sda_next  = !ackc_reg;
                                step_next = STEP_W'(2);
                            end else begin
                                step_next = '0;
                            end
                        end else if (step_reg == STEP_W'(2)) begin
                            scl_next  = 1'b1;
                            step_next = STEP_W'(3);
                        end else begin
                            scl_next     = 1'b0;
                            rx_last_next = shift_reg;
                            done         = 1'b1;
                            rxv          = 1'b1;
                        end
                    end
                end
                default: begin
                    // Idle: a tick changes nothing.
                end
            endcase
            if (done) begin
                cmd_next   = CMD_IDLE;
                step_next  = '0;
                delay_next = '0;
            end
        end

        res_next.scl_out  = scl_next;
        res_next.sda_out  = sda_next;
        res_next.busy_res = (cmd_next != CMD_IDLE);
        res_next.rx_byte  = rx_last_next;
        res_next.rx_valid = rxv;
        res_next.ack_fail = fail;
        res_next.done_res = done;

        if (step_en) begin
            res_valid_next = 1'b1;
        end else if (res_ready) begin
            res_valid_next = 1'b0;
        end else begin
            res_valid_next = res_valid_reg;
        end
    end

    // Sequencer state and result valid.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cmd_reg       <= CMD_IDLE;
            step_reg      <= '0;
            bitc_reg      <= '0;
            shift_reg     <= '0;
            delay_reg     <= '0;
            tmo_reg       <= '0;
            ackc_reg      <= 1'b0;
            scl_reg       <= 1'b1;
            sda_reg       <= 1'b1;
            rx_last_reg   <= '0;
            res_valid_reg <= 1'b0;
        end else begin
            res_valid_reg <= res_valid_next;
            if (step_en) begin
                cmd_reg     <= cmd_next;
                step_reg    <= step_next;
                bitc_reg    <= bitc_next;
                shift_reg   <= shift_next;
                delay_reg   <= delay_next;
                tmo_reg     <= tmo_next;
                ackc_reg    <= ackc_next;
                scl_reg     <= scl_next;
                sda_reg     <= sda_next;
                rx_last_reg <= rx_last_next;
            end
        end
    end

    // Result payload register.
    always_ff @(posedge aclk) begin
        if (step_en) begin
            res_reg <= res_next;
        end
    end

    assign res_valid = res_valid_reg;
    assign res       = res_reg;

endmodule

/* hdl/i2c_master_bit_engine_core.sv */
// I2C master bit engine, top level: command queue front, line engine back.
// Depends on i2cm_pkg, i2cm_cmd_queue and i2cm_line_engine.
//
// Usage:
// Each input beat on the s_ channel is one command (start, stop, send byte,
// wait for acknowledge, read byte) or one time tick carrying the sampled SDA
// level; s_tuser holds the op code. Every accepted beat yields exactly one
// result beat on the m_ channel with the SCL/SDA drive levels and status.
// Phase length and acknowledge timeout are set through the cfg_ channel,
// which is always ready; the user writes it only while the engine has no
// beat in flight, as the block does not enforce this. Throughput is one
// beat per cycle unless the receiver stalls: the line engine advances its phase
// sequencer one step per beat, each via the queue and the result register.
// When the receiver stalls, results wait in the result register and the queue
// fills; s_tready drops once the queue holds QUEUE_DEPTH items.
// Reset (aresetn low, synchronous) releases both lines high, empties the
// queue and restores phase_ticks to 5 and ack_timeout to 250.
module i2c_master_bit_engine_core
    import i2cm_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    // Input beats.
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // tdata: tx_byte[7:0], ack_after_read[8], sda_in[9], zero[15:10]
    input  logic [S_TDATA_W-1:0]  s_tdata,
    // tuser: op[2:0]
    input  logic [OP_W-1:0]       s_tuser,
    // Result beats.
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // tdata: scl_out[0], sda_out[1], busy_res[2], rx_byte[10:3], rx_valid[11],
    //        ack_fail[12], done_res[13], zero[15:14]
    output logic [M_TDATA_W-1:0]  m_tdata,
    // Configuration writes.
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    logic    q_valid;
    logic    q_ready;
    item_t   q_item;
    result_t res;

    assign cfg_ready = 1'b1;

    i2cm_cmd_queue #(
        .DEPTH(QUEUE_DEPTH)
    ) u_queue (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .in_valid         (s_tvalid),
        .in_ready         (s_tready),
        .in_op            (s_tuser),
        .in_tx_byte       (s_tdata[BYTE_W-1:0]),
        .in_ack_after_read(s_tdata[BYTE_W]),
        .in_sda_in        (s_tdata[BYTE_W+1]),
        .q_valid          (q_valid),
        .q_ready          (q_ready),
        .q_item           (q_item)
    );

    i2cm_line_engine u_engine (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg_we   (cfg_valid && cfg_ready),
        .cfg_idx  (cfg_index),
        .cfg_wdata(cfg_data),
        .q_valid  (q_valid),
        .q_ready  (q_ready),
        .q_item   (q_item),
        .res_valid(m_tvalid),
        .res_ready(m_tready),
        .res      (res)
    );

    // Pack the result fields, highest bit first.
    assign m_tdata = {2'b00, res.done_res, res.ack_fail, res.rx_valid, res.rx_byte,
                      res.busy_res, res.sda_out, res.scl_out};

`ifndef ASSERT_OFF
    // A finished command leaves the engine idle.
    a_done_not_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !(res.done_res && res.busy_res))
        else $error("done result still reports busy");

    // A timed-out acknowledge ends with the stop condition: both lines released.
    a_fail_stop: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && res.ack_fail) |-> (res.done_res && res.scl_out && res.sda_out))
        else $error("ack failure without completed stop");

    // A completed read is a finished command and never a failed acknowledge.
    a_rx_done: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && res.rx_valid) |-> (res.done_res && !res.ack_fail && !res.scl_out))
        else $error("read completion with inconsistent status");
`endif

endmodule
